// File: rtl/core/tlvd_pkg.sv
package tlvd_pkg;

  // Default width of the tag and length accumulators.
  localparam int unsigned FieldWidthDef = 16;

  // Width of the tag and length result ports.
  localparam int unsigned OutFieldWidth = 16;

  // A byte of this value continues the tag or length run.
  localparam logic [7:0] RunByte = 8'hFF;

  // Reset value of the maximum value size register.
  localparam logic [15:0] MaxValueSizeRst = 16'd4096;

  // Configuration register indexes.
  localparam logic RegMaxValueSize = 1'b0;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_HEADER   = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_TAG   = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DROP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic                       valid;
    kind_e                      kind;
    logic [OutFieldWidth-1:0]   tag;
    logic [OutFieldWidth-1:0]   length;
    logic [7:0]                 value_byte;
    logic                       last;
    err_e                       err;
  } result_t;

endpackage

// File: rtl/core/tlvd_parser.sv
module tlvd_parser #(
  parameter int unsigned FieldWidth = tlvd_pkg::FieldWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_buffer_i,
  input  logic [15:0]       max_value_size_i,
  output tlvd_pkg::result_t res_o
);

  localparam int unsigned CmpWidth = (FieldWidth > 16) ? FieldWidth : 16;

  tlvd_pkg::phase_e        phase_q, phase_d;
  logic [FieldWidth-1:0]   tag_q, tag_d;
  logic [FieldWidth-1:0]   len_q, len_d;
  logic [FieldWidth-1:0]   rem_q, rem_d;

  logic [FieldWidth:0]     tag_sum, len_sum;
  logic [FieldWidth-1:0]   tag_sat, len_sat;
  logic [FieldWidth-1:0]   tag_cur, len_cur;
  logic                    is_run;
  logic                    too_long;
  logic                    clear;

  // Saturating header accumulation.
  assign tag_sum  = {1'b0, tag_q} + (FieldWidth + 1)'(data_byte_i);
  assign len_sum  = {1'b0, len_q} + (FieldWidth + 1)'(data_byte_i);
  assign tag_sat  = tag_sum[FieldWidth] ? '1 : tag_sum[FieldWidth-1:0];
  assign len_sat  = len_sum[FieldWidth] ? '1 : len_sum[FieldWidth-1:0];
  assign is_run   = (data_byte_i == tlvd_pkg::RunByte);
  assign too_long = CmpWidth'(len_sat) > CmpWidth'(max_value_size_i);

  always_comb begin
    phase_d          = phase_q;
    rem_d            = rem_q;
    tag_cur          = tag_q;
    len_cur          = len_q;
    clear            = 1'b0;
    res_o.valid      = 1'b0;
    res_o.kind       = tlvd_pkg::KIND_VALUE;
    res_o.value_byte = 8'd0;
    res_o.last       = 1'b0;
    res_o.err        = tlvd_pkg::ERR_NONE;

    unique case (phase_q)
      tlvd_pkg::PH_TAG: begin
        tag_cur = tag_sat;
        if (!is_run) begin
          phase_d = tlvd_pkg::PH_LEN;
        end
        if (end_of_buffer_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = tlvd_pkg::KIND_ERROR;
          res_o.err   = tlvd_pkg::ERR_HEADER;
          clear       = 1'b1;
        end
      end
      tlvd_pkg::PH_LEN: begin
        len_cur = len_sat;
        if (is_run) begin
          if (end_of_buffer_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = tlvd_pkg::KIND_ERROR;
            res_o.err   = tlvd_pkg::ERR_HEADER;
            clear       = 1'b1;
          end
        end else if (too_long) begin
          // The size check wins over a truncated buffer.
          res_o.valid = 1'b1;
          res_o.kind  = tlvd_pkg::KIND_ERROR;
          res_o.err   = tlvd_pkg::ERR_TOO_LONG;
          if (end_of_buffer_i) begin
            clear = 1'b1;
          end else begin
            phase_d = tlvd_pkg::PH_DROP;
          end
        end else if (len_sat == '0) begin
          res_o.valid = 1'b1;
          res_o.kind  = tlvd_pkg::KIND_EMPTY;
          res_o.last  = 1'b1;
          clear       = 1'b1;
        end else if (end_of_buffer_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = tlvd_pkg::KIND_ERROR;
          res_o.err   = tlvd_pkg::ERR_TRUNC;
          clear       = 1'b1;
        end else begin
          rem_d   = len_sat;
          phase_d = tlvd_pkg::PH_VALUE;
        end
      end
      tlvd_pkg::PH_VALUE: begin
        if (rem_q <= FieldWidth'(1)) begin
          res_o.valid      = 1'b1;
          res_o.value_byte = data_byte_i;
          res_o.last       = 1'b1;
          clear            = 1'b1;
        end else if (end_of_buffer_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = tlvd_pkg::KIND_ERROR;
          res_o.err   = tlvd_pkg::ERR_TRUNC;
          clear       = 1'b1;
        end else begin
          res_o.valid      = 1'b1;
          res_o.value_byte = data_byte_i;
          rem_d            = rem_q - FieldWidth'(1);
        end
      end
      tlvd_pkg::PH_DROP: begin
        if (end_of_buffer_i) begin
          clear = 1'b1;
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase

    // Results report the header as updated by this byte.
    res_o.tag    = tlvd_pkg::OutFieldWidth'(tag_cur);
    res_o.length = tlvd_pkg::OutFieldWidth'(len_cur);

    tag_d = tag_cur;
    len_d = len_cur;
    if (clear) begin
      phase_d = tlvd_pkg::PH_TAG;
      tag_d   = '0;
      len_d   = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tlvd_pkg::PH_TAG;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_value_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tlvd_pkg::PH_VALUE |-> rem_q != '0)
    else $error("value phase with no bytes remaining");

  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_of_buffer_i |=>
      phase_q == tlvd_pkg::PH_TAG && tag_q == '0 && len_q == '0 && rem_q == '0)
    else $error("buffer end did not clear the record state");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tlvd_pkg::PH_DROP |-> !res_o.valid)
    else $error("result produced while dropping");

  a_empty_from_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == tlvd_pkg::KIND_EMPTY |->
      phase_q == tlvd_pkg::PH_LEN && res_o.length == '0)
    else $error("empty record outside the length phase");
`endif

endmodule

// File: rtl/core/tlv_run_length_deframer.sv
// Deframer for back-to-back tag-length-value records, one byte per request.
// Tag and length are each a run of 0xFF bytes (each adding 255) closed by one
// byte below 0xFF that is added; both saturate at the all-ones value of the
// accumulator width. Each value byte leaves as one result carrying the tag
// and length, with last_of_value set on the final byte; a zero-length record
// gives one empty-record result. A buffer ending inside the header, a length
// above max_value_size, or a buffer ending inside the value gives an error
// result; after a length error, bytes are dropped to the end_of_buffer byte.
// For every byte taken, the record state is updated and the result, if any, is
// written into the output register at the same clock edge, so the block
// sustains one byte per cycle while the output register is not stalled. The
// only stall comes from the output register: a new byte is taken whenever
// that register is empty or is being drained in the same cycle.
module tlv_run_length_deframer #(
  parameter int unsigned FieldWidth = tlvd_pkg::FieldWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Byte input.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,

  // Result output.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] record_tag_o,
  output logic [15:0] record_length_o,
  output logic [7:0]  value_byte_o,
  output logic        last_of_value_o,
  output logic [1:0]  error_code_o
);

  logic [15:0]       max_size_q;
  logic              cfg_write;
  logic              accept;
  tlvd_pkg::result_t step_res;
  tlvd_pkg::result_t out_q;
  logic              out_valid_q;

  // Register index is the word address paddr[2]; the low two bits are not decoded.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= tlvd_pkg::MaxValueSizeRst;
    end else if (cfg_write && (paddr[2] == tlvd_pkg::RegMaxValueSize)) begin
      max_size_q <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == tlvd_pkg::RegMaxValueSize) begin
      prdata = {16'd0, max_size_q};
    end else begin
      prdata = 32'd0;
    end
  end

  // A byte is taken when the output register is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  tlvd_parser #(
    .FieldWidth (FieldWidth)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .data_byte_i      (data_byte_i),
    .end_of_buffer_i  (end_of_buffer_i),
    .max_value_size_i (max_size_q),
    .res_o            (step_res)
  );

  // Output register: a byte that yields no result leaves it empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= step_res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign record_tag_o    = out_q.tag;
  assign record_length_o = out_q.length;
  assign value_byte_o    = out_q.value_byte;
  assign last_of_value_o = out_q.last;
  assign error_code_o    = out_q.err;

endmodule
